/* src/spq_pkg.sv */
// Package with the shared types, codes and defaults of the stable priority ready queue.
`default_nettype none

package spq_pkg;

    localparam int SPQ_DEPTH = 16;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_STATUS  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        op_t        opcode;
        logic [7:0] process_id;
        logic [7:0] entry_priority;
    } request_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] taken_id;
        logic [7:0] taken_priority;
        logic       head_valid;
        logic [7:0] head_id;
        logic [7:0] head_priority;
        logic [4:0] entry_count;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic compare;
        logic apply;
    } cmd_t;

endpackage

`default_nettype wire

/* src/stable_priority_ready_queue_top.sv */
// Top level of the stable priority ready queue.
//
//  Channel   Signals                 Direction  Transaction completes when
//  -------   ---------------------   ---------  ---------------------------------
//  request   start, busy, request    in         start is high and busy is low
//  result    done, result            out        every cycle that done is high
//
// Each transaction runs in order: the request is captured at the accepting edge,
// then every slot compares its priority and id against the request, and then
// all slots shift at once and the result register loads. The result strobe
// shows in the cycle after that, and busy is already low then, so a new
// transaction can be taken while a result is shown; busy holds off a new one
// through the compare step and the single shift step over the slots.
// Reset clears the state machine and the entry count; slot contents are left
// as they are and are never read beyond the count. The receiver cannot stall:
// a result is shown for one cycle only.
`default_nettype none

module stable_priority_ready_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire request_t request,
    output logic          busy,
    output logic          done,
    output result_t       result
);

    cmd_t cmd;

    // The controller sequences capture, compare and update.
    spq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // The datapath holds the sorted slots and builds the result.
    spq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .result  (result)
    );

endmodule

`default_nettype wire

/* src/spq_ctrl.sv */
// Controller state machine of the stable priority ready queue.
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output logic      done,
    output cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_COMPARE = 3'b010,
        S_UPDATE  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE: state_next = S_UPDATE;
            S_UPDATE:  state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_UPDATE);
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign cmd.load    = (state_reg == S_IDLE) && start;
    assign cmd.compare = (state_reg == S_COMPARE);
    assign cmd.apply   = (state_reg == S_UPDATE);

endmodule

`default_nettype wire

/* src/spq_dpath.sv */
// Datapath of the stable priority ready queue: slot cells, compare vectors and result register.
`default_nettype none

module spq_dpath
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cmd_t     cmd,
    input  wire request_t request,
    output result_t       result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t             op_reg;
    logic [7:0]      id_reg;
    logic [7:0]      pri_reg;
    logic [7:0]      ids_reg  [DEPTH];
    logic [7:0]      pris_reg [DEPTH];
    logic [7:0]      ids_next [DEPTH];
    logic [7:0]      pris_next[DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [DEPTH-1:0] ge_reg;
    logic [DEPTH-1:0] match_reg;
    result_t         result_reg;
    result_t         result_next;

    // Neighbor views of every cell, fixed by position.
    logic [7:0]       up_id  [DEPTH];
    logic [7:0]       up_pri [DEPTH];
    logic [7:0]       dn_id  [DEPTH];
    logic [7:0]       dn_pri [DEPTH];
    logic [DEPTH-1:0] ge_prev;

    logic [DEPTH-1:0] first_hit;
    logic [DEPTH-1:0] below_hit;
    logic [DEPTH-1:0] shift_vec;
    logic             found;
    logic             full;
    logic             empty;
    logic [7:0]       hit_id;
    logic [7:0]       hit_pri;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_nbr
        if (g == 0)
        begin : g_first
            assign up_id[g]   = id_reg;
            assign up_pri[g]  = pri_reg;
            assign ge_prev[g] = 1'b1;
        end
        else
        begin : g_inner
            assign up_id[g]   = ids_reg[g-1];
            assign up_pri[g]  = pris_reg[g-1];
            assign ge_prev[g] = ge_reg[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign dn_id[g]  = ids_reg[g];
            assign dn_pri[g] = pris_reg[g];
        end
        else
        begin : g_body
            assign dn_id[g]  = ids_reg[g+1];
            assign dn_pri[g] = pris_reg[g+1];
        end
    end

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign found     = |match_reg;
    // Lowest set match bit, then a mask of the slots ahead of it.
    assign first_hit = match_reg & (~match_reg + DEPTH'(1));
    assign below_hit = first_hit - DEPTH'(1);

    always_comb
    begin
        hit_id  = '0;
        hit_pri = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_id  = hit_id  | ({8{first_hit[i]}} & ids_reg[i]);
            hit_pri = hit_pri | ({8{first_hit[i]}} & pris_reg[i]);
        end
    end

    always_comb
    begin
        shift_vec = '0;
        case (op_reg)
            OP_DEQUEUE: shift_vec = empty ? '0 : '1;
            OP_REMOVE:  shift_vec = found ? ~below_hit : '0;
            default:    shift_vec = '0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ids_next[i]  = ids_reg[i];
            pris_next[i] = pris_reg[i];
            if (op_reg == OP_ENQUEUE)
            begin
                if (!full && !ge_reg[i])
                begin
                    if (ge_prev[i])
                    begin
                        ids_next[i]  = id_reg;
                        pris_next[i] = pri_reg;
                    end
                    else
                    begin
                        ids_next[i]  = up_id[i];
                        pris_next[i] = up_pri[i];
                    end
                end
            end
            else if (shift_vec[i])
            begin
                ids_next[i]  = dn_id[i];
                pris_next[i] = dn_pri[i];
            end
        end
    end

    always_comb
    begin
        count_next                 = count_reg;
        result_next.status         = STAT_OK;
        result_next.taken_id       = '0;
        result_next.taken_priority = '0;
        case (op_reg)
            OP_ENQUEUE:
            begin
                if (full)
                begin
                    result_next.status = STAT_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DEQUEUE:
            begin
                if (empty)
                begin
                    result_next.status = STAT_EMPTY;
                end
                else
                begin
                    count_next                 = count_reg - CNT_W'(1);
                    result_next.taken_id       = ids_reg[0];
                    result_next.taken_priority = pris_reg[0];
                end
            end
            OP_REMOVE:
            begin
                if (!found)
                begin
                    result_next.status = STAT_NOT_FOUND;
                end
                else
                begin
                    count_next                 = count_reg - CNT_W'(1);
                    result_next.taken_id       = hit_id;
                    result_next.taken_priority = hit_pri;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        result_next.head_valid    = (count_next != '0);
        result_next.head_id       = (count_next != '0) ? ids_next[0] : '0;
        result_next.head_priority = (count_next != '0) ? pris_next[0] : '0;
        result_next.entry_count   = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.apply)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= request.opcode;
            id_reg  <= request.process_id;
            pri_reg <= request.entry_priority;
        end
        if (cmd.compare)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                ge_reg[i]    <= (CNT_W'(i) < count_reg) && (pris_reg[i] >= pri_reg);
                match_reg[i] <= (CNT_W'(i) < count_reg) && (ids_reg[i] == id_reg);
            end
        end
        if (cmd.apply)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                ids_reg[i]  <= ids_next[i];
                pris_reg[i] <= pris_next[i];
            end
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* src/spq_checker.sv */
// Port-level checker of the stable priority ready queue and its bind statement.
`default_nettype none

module spq_checker
    import spq_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     done,
    input wire result_t  result
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted transaction");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##2 done)
        else $error("result did not appear three cycles after acceptance");

    a_idle_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while a result is shown");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.head_valid |-> result.head_id == 8'd0 && result.head_priority == 8'd0)
        else $error("head fields not zero on an empty queue");

    a_failed_taken: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != STAT_OK |-> result.taken_id == 8'd0
            && result.taken_priority == 8'd0)
        else $error("taken fields not zero on a failed transaction");

endmodule

bind stable_priority_ready_queue_top spq_checker u_spq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
